[rtl/bcomp_pkg.sv]
// Shared types, widths and constants of the barometric compensation unit.
package bcomp_pkg;

   // Field and register widths
   localparam int REG_W   = 16;
   localparam int RAW_W   = 24;
   localparam int VALUE_W = 23;
   localparam int DELTA_W = 26;
   localparam int IDX_W   = 3;

   // Serial multiplier widths: signed multiplicand, unsigned multiplier, full product
   localparam int MCAND_W = 36;
   localparam int MPLR_W  = 24;
   localparam int PROD_W  = MCAND_W + MPLR_W;
   localparam int CNT_W   = $clog2(MPLR_W);

   // Width of the offset term and of the final difference
   localparam int OFF_W = 40;

   // Temperature result base, in hundredths of a degree
   localparam logic [VALUE_W-1:0] TEMP_BASE = 23'd2000;

   // Configuration register indexes
   typedef enum logic [IDX_W-1:0] {
      REG_SENS        = 3'd0,
      REG_OFF         = 3'd1,
      REG_SENS_TEMP   = 3'd2,
      REG_OFF_TEMP    = 3'd3,
      REG_REF_TEMP    = 3'd4,
      REG_TEMP_COEFF  = 3'd5
   } reg_index_type;

   // Calibration words as seen by the datapath
   typedef struct packed {
      logic [REG_W-1:0] sens_coeff;
      logic [REG_W-1:0] offset_coeff;
      logic [REG_W-1:0] sens_temp_coeff;
      logic [REG_W-1:0] offset_temp_coeff;
      logic [REG_W-1:0] ref_temp;
      logic [REG_W-1:0] temp_coeff;
   } cfg_type;

   // Request to the serial multiplier
   typedef struct packed {
      logic                      start;
      logic signed [MCAND_W-1:0] mcand;
      logic [MPLR_W-1:0]         mplr;
   } mult_req_type;

   // Status and result of the serial multiplier
   typedef struct packed {
      logic                     done;
      logic signed [PROD_W-1:0] product;
   } mult_rsp_type;

endpackage

[rtl/bcomp_ifs.sv]
// Valid/ready channel interfaces for conversion requests and compensated results.
interface bcomp_req_if;
   logic                          valid;
   logic                          ready;
   logic                          func;
   logic [bcomp_pkg::RAW_W-1:0]   raw_code;

   modport source (output valid, output func, output raw_code, input ready);
   modport sink   (input valid, input func, input raw_code, output ready);
endinterface

interface bcomp_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               kind;
   logic signed [bcomp_pkg::VALUE_W-1:0] value;

   modport source (output valid, output kind, output value, input ready);
   modport sink   (input valid, input kind, input value, output ready);
endinterface

[rtl/bcomp_csr.sv]
// Calibration register file written through the plain configuration port.
module bcomp_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [bcomp_pkg::IDX_W-1:0]    csr_index,
   input  logic [bcomp_pkg::REG_W-1:0]    csr_wr_data,
   output bcomp_pkg::cfg_type             cfg
);

   bcomp_pkg::cfg_type cfg_ff;

   // Decode the index; indexes past the last register are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            bcomp_pkg::REG_SENS:       cfg_ff.sens_coeff        <= csr_wr_data;
            bcomp_pkg::REG_OFF:        cfg_ff.offset_coeff      <= csr_wr_data;
            bcomp_pkg::REG_SENS_TEMP:  cfg_ff.sens_temp_coeff   <= csr_wr_data;
            bcomp_pkg::REG_OFF_TEMP:   cfg_ff.offset_temp_coeff <= csr_wr_data;
            bcomp_pkg::REG_REF_TEMP:   cfg_ff.ref_temp          <= csr_wr_data;
            bcomp_pkg::REG_TEMP_COEFF: cfg_ff.temp_coeff        <= csr_wr_data;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/bcomp_serial_mult.sv]
// Bit-serial shift-add multiplier: signed multiplicand times unsigned multiplier.
module bcomp_serial_mult (
   input  logic                    clock,
   input  logic                    reset,
   input  bcomp_pkg::mult_req_type mult_req,
   output bcomp_pkg::mult_rsp_type mult_rsp
);

   logic                                busy_ff;
   logic                                done_ff;
   logic [bcomp_pkg::CNT_W-1:0]         cnt_ff;
   logic signed [bcomp_pkg::MCAND_W-1:0] mcand_ff;
   logic [bcomp_pkg::MPLR_W-1:0]        mplr_ff;
   logic signed [bcomp_pkg::MCAND_W-1:0] hi_ff;
   logic [bcomp_pkg::MPLR_W-1:0]        lo_ff;

   logic signed [bcomp_pkg::MCAND_W-1:0] addend;
   logic signed [bcomp_pkg::MCAND_W-1:0] sum;
   logic                                last;

   // One multiplier bit per cycle. The running sum stays below twice the
   // multiplicand in magnitude, so it fits the multiplicand width.
   always_comb begin
      addend = mplr_ff[0] ? mcand_ff : '0;
      sum    = hi_ff + addend;
      last   = (cnt_ff == bcomp_pkg::CNT_W'(bcomp_pkg::MPLR_W - 1));
   end

   // Control: busy while bits remain, one-cycle done after the last bit.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && last;
         if (mult_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + bcomp_pkg::CNT_W'(1);
            if (last) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // Datapath: the high half shifts right arithmetically, the low bits
   // of the product leave the sum one per cycle.
   always_ff @(posedge clock) begin
      if (mult_req.start) begin
         mcand_ff <= mult_req.mcand;
         mplr_ff  <= mult_req.mplr;
         hi_ff    <= '0;
         lo_ff    <= '0;
      end else if (busy_ff) begin
         mplr_ff <= mplr_ff >> 1;
         hi_ff   <= sum >>> 1;
         lo_ff   <= {sum[0], lo_ff[bcomp_pkg::MPLR_W-1:1]};
      end
   end

   assign mult_rsp.done    = done_ff;
   assign mult_rsp.product = {hi_ff, lo_ff};

endmodule

[rtl/baro_pressure_temp_compensation_unit.sv]
// Top level of the barometric first-order temperature and pressure compensation unit.
//
// Usage: a request word carries func (0 temperature, 1 pressure) and the 24-bit raw
// converter code on req_ch. A temperature word stores the difference to the
// reference temperature and returns the temperature in 0.01 degC; a pressure word
// uses the last stored difference and returns the pressure in 0.01 mbar. Each
// request gives exactly one response word on rsp_ch, with kind equal to func.
// Calibration words are written through csr_wr_en / csr_index / csr_wr_data while
// the unit is idle; the user is bound to this, the unit does not enforce it.
// Indexes past the last register are ignored. One shared bit-serial multiplier
// retires one multiplier bit per cycle. A temperature word runs one product; a
// pressure word runs three products in sequence. req_ch.ready returns in the same
// cycle the response is shown, so the unit takes no new word before the last one
// is through. The response sits in an output register; if the receiver stalls,
// the finished result waits inside and the next request is held off.
// Reset clears all calibration words, the stored temperature difference and
// the response valid; the unit is ready right after reset.
module baro_pressure_temp_compensation_unit (
   input  logic                        clock,
   input  logic                        reset,
   bcomp_req_if.sink                   req_ch,
   bcomp_rsp_if.source                 rsp_ch,
   input  logic                        csr_wr_en,
   input  logic [bcomp_pkg::IDX_W-1:0] csr_index,
   input  logic [bcomp_pkg::REG_W-1:0] csr_wr_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TEMP,
      ST_OFF,
      ST_SENS,
      ST_PRES,
      ST_OUT
   } state_type;

   state_type                              state_ff;
   bcomp_pkg::cfg_type                     cfg;
   bcomp_pkg::mult_req_type                mult_req_ff;
   bcomp_pkg::mult_rsp_type                mult_rsp;

   logic                                   func_ff;
   logic [bcomp_pkg::RAW_W-1:0]            raw_ff;
   logic signed [bcomp_pkg::DELTA_W-1:0]   temp_delta_ff;
   logic signed [bcomp_pkg::OFF_W-1:0]     off_ff;
   logic [bcomp_pkg::VALUE_W-1:0]          result_ff;
   logic                                   rsp_valid_ff;
   logic                                   rsp_kind_ff;
   logic [bcomp_pkg::VALUE_W-1:0]          rsp_value_ff;

   logic signed [bcomp_pkg::DELTA_W-1:0]   temp_delta_in;
   logic signed [bcomp_pkg::OFF_W-1:0]     off_in;
   logic signed [bcomp_pkg::MCAND_W-1:0]   sens_in;
   logic signed [bcomp_pkg::OFF_W-1:0]     pres_diff;
   logic signed [bcomp_pkg::MCAND_W-1:0]   delta_ext;
   logic signed [bcomp_pkg::MCAND_W-1:0]   delta_in_ext;

   // Calibration registers
   bcomp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   // Shared serial multiplier
   bcomp_serial_mult u_mult (
      .clock    (clock),
      .reset    (reset),
      .mult_req (mult_req_ff),
      .mult_rsp (mult_rsp)
   );

   // Arithmetic around the products. Only the low bits of each sum matter for
   // the result field, so the truncations below drop nothing that is used.
   always_comb begin
      temp_delta_in = {2'b00, req_ch.raw_code} - {2'b00, cfg.ref_temp, 8'h00};
      delta_in_ext  = {{(bcomp_pkg::MCAND_W - bcomp_pkg::DELTA_W){temp_delta_in[25]}},
                       temp_delta_in};
      delta_ext     = {{(bcomp_pkg::MCAND_W - bcomp_pkg::DELTA_W){temp_delta_ff[25]}},
                       temp_delta_ff};
      off_in        = mult_rsp.product[46:7] + {8'h00, cfg.offset_coeff, 16'h0000};
      sens_in       = mult_rsp.product[43:8] + {5'b00000, cfg.sens_coeff, 15'h0000};
      pres_diff     = {mult_rsp.product[59], mult_rsp.product[59:21]} - off_ff;
   end

   // Sequencer: state, multiplier requests and the response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         mult_req_ff.start <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         temp_delta_ff     <= '0;
      end else begin
         // A product starts on an accepted word and after the offset and
         // sensitivity products of a pressure word.
         mult_req_ff.start <= ((state_ff == ST_IDLE) && req_ch.valid) ||
                              (((state_ff == ST_OFF) || (state_ff == ST_SENS)) &&
                               mult_rsp.done);
         // The output stage always leaves a word shown; otherwise a shown
         // word stays until it is taken.
         rsp_valid_ff <= (state_ff == ST_OUT) || (rsp_valid_ff && !rsp_ch.ready);
         unique case (state_ff)
            ST_IDLE: begin
               if (req_ch.valid) begin
                  func_ff           <= req_ch.func;
                  raw_ff            <= req_ch.raw_code;
                  if (!req_ch.func) begin
                     temp_delta_ff    <= temp_delta_in;
                     mult_req_ff.mcand <= delta_in_ext;
                     mult_req_ff.mplr  <= {8'h00, cfg.temp_coeff};
                     state_ff          <= ST_TEMP;
                  end else begin
                     mult_req_ff.mcand <= delta_ext;
                     mult_req_ff.mplr  <= {8'h00, cfg.offset_temp_coeff};
                     state_ff          <= ST_OFF;
                  end
               end
            end
            ST_TEMP: begin
               if (mult_rsp.done) begin
                  result_ff <= mult_rsp.product[45:23] + bcomp_pkg::TEMP_BASE;
                  state_ff  <= ST_OUT;
               end
            end
            ST_OFF: begin
               if (mult_rsp.done) begin
                  off_ff            <= off_in;
                  mult_req_ff.mcand <= delta_ext;
                  mult_req_ff.mplr  <= {8'h00, cfg.sens_temp_coeff};
                  state_ff          <= ST_SENS;
               end
            end
            ST_SENS: begin
               if (mult_rsp.done) begin
                  mult_req_ff.mcand <= sens_in;
                  mult_req_ff.mplr  <= raw_ff;
                  state_ff          <= ST_PRES;
               end
            end
            ST_PRES: begin
               if (mult_rsp.done) begin
                  result_ff <= pres_diff[37:15];
                  state_ff  <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_kind_ff  <= func_ff;
                  rsp_value_ff <= result_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Channel outputs
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.kind  = rsp_kind_ff;
   assign rsp_ch.value = rsp_value_ff;

endmodule

[rtl/bcomp_checker.sv]
// Port-level checks of the compensation unit and the bind that attaches them.
module bcomp_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_kind
);

   // A stalled response word keeps its valid and its kind.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind))
      else $error("response word dropped or changed while stalled");

   // The unit works on one word at a time: an accepted request closes the input.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while a word is in flight");

   // The input only closes because a word was taken.
   assert property (@(posedge clock) disable iff (reset)
      $fell(req_ready) |-> $past(req_valid))
      else $error("input closed without an accepted request");

   // Reset leaves no response pending.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind baro_pressure_temp_compensation_unit bcomp_checker u_bcomp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_kind  (rsp_ch.kind)
);

[tb/tb_baro_pressure_temp_compensation_unit.sv]
// Self-checking testbench of the barometric compensation unit, with its own predictor.
`timescale 1ns / 100ps

module tb_baro_pressure_temp_compensation_unit;

   // Conversion kinds on the request channel and in the result word
   typedef enum logic {
      CONV_TEMP = 1'b0,
      CONV_PRES = 1'b1
   } conv_kind_type;

   typedef logic [bcomp_pkg::RAW_W-1:0] raw_type;
   typedef logic [bcomp_pkg::REG_W-1:0] word_type;

   // Register indexes past the last register; writes to them are dropped
   localparam logic [bcomp_pkg::IDX_W-1:0] IDX_SPARE_LO = 3'd6;
   localparam logic [bcomp_pkg::IDX_W-1:0] IDX_SPARE_HI = 3'd7;

   localparam raw_type  RAW_MAX     = {bcomp_pkg::RAW_W{1'b1}};
   localparam word_type WORD_MAX    = {bcomp_pkg::REG_W{1'b1}};
   localparam int       RAND_PHASES = 8;
   localparam int       CYCLE_LIMIT = 500000;

   typedef struct packed {
      logic    func;
      raw_type raw;
   } conv_word_type;

   typedef struct packed {
      logic                                 kind;
      logic signed [bcomp_pkg::VALUE_W-1:0] value;
   } reading_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [bcomp_pkg::IDX_W-1:0] csr_index;
   word_type csr_wr_data;

   bcomp_req_if req_ch ();
   bcomp_rsp_if rsp_ch ();

   baro_pressure_temp_compensation_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // Predictor state: calibration words and the stored temperature difference.
   bcomp_pkg::cfg_type                   cal;
   logic signed [bcomp_pkg::DELTA_W-1:0] temp_delta;

   conv_word_type conversions_pending[$];
   reading_type   readings_due[$];

   logic steady;
   int   errors;
   int   readings_seen;
   int   cycles;
   int   hold_left;
   logic hold_used;

   // Expected result of one conversion word; a temperature word also updates the delta.
   function automatic reading_type compensate(input logic func, input raw_type raw);
      longint      dt;
      longint      offs;
      longint      sens;
      longint      res;
      reading_type r;
      dt = longint'(temp_delta);
      if (func == CONV_TEMP) begin
         dt = longint'(raw) - (longint'(cal.ref_temp) << 8);
         temp_delta = dt[bcomp_pkg::DELTA_W-1:0];
         res = longint'(bcomp_pkg::TEMP_BASE)
             + ((dt * longint'(cal.temp_coeff)) >>> 23);
      end else begin
         offs = (longint'(cal.offset_coeff) << 16)
              + ((longint'(cal.offset_temp_coeff) * dt) >>> 7);
         sens = (longint'(cal.sens_coeff) << 15)
              + ((longint'(cal.sens_temp_coeff) * dt) >>> 8);
         res = (((longint'(raw) * sens) >>> 21) - offs) >>> 15;
      end
      r.kind  = func;
      r.value = res[bcomp_pkg::VALUE_W-1:0];
      return r;
   endfunction

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Cycle count and run limit.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("baro_pressure_temp_compensation_unit verification failed");
         $finish;
      end
   end

   // Request driver: predicts each accepted word and offers the next pending one.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            readings_due.push_back(compensate(req_ch.func, req_ch.raw_code));
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (conversions_pending.size() != 0 && (steady || $urandom_range(99) >= 21)) begin
               req_ch.valid    <= 1'b1;
               req_ch.func     <= conversions_pending[0].func;
               req_ch.raw_code <= conversions_pending[0].raw;
               conversions_pending.pop_front();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Result receiver: random stalls, plus one long hold-off that lets the unit back up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else if (!hold_used && readings_seen >= 150) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= 600;
         hold_used    <= 1'b1;
      end else begin
         rsp_ch.ready <= steady || ($urandom_range(99) >= 21);
      end
   end

   // Result monitor: compares each accepted word with the oldest prediction.
   always @(posedge clock) begin
      reading_type exp_r;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         readings_seen <= readings_seen + 1;
         if (readings_due.size() == 0) begin
            $error("unexpected result word: kind %0d value %0d", rsp_ch.kind, rsp_ch.value);
            errors = errors + 1;
         end else begin
            exp_r = readings_due.pop_front();
            if (rsp_ch.kind !== exp_r.kind) begin
               $error("kind mismatch: expected %0d, actual %0d", exp_r.kind, rsp_ch.kind);
               errors = errors + 1;
            end
            if (rsp_ch.value !== exp_r.value) begin
               $error("value mismatch: expected %0d, actual %0d", exp_r.value, rsp_ch.value);
               errors = errors + 1;
            end
         end
      end
   end

   // One register write; the predictor copy follows the same index decode.
   task automatic write_reg(input logic [bcomp_pkg::IDX_W-1:0] idx, input word_type data);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      case (idx)
         bcomp_pkg::REG_SENS:       cal.sens_coeff        = data;
         bcomp_pkg::REG_OFF:        cal.offset_coeff      = data;
         bcomp_pkg::REG_SENS_TEMP:  cal.sens_temp_coeff   = data;
         bcomp_pkg::REG_OFF_TEMP:   cal.offset_temp_coeff = data;
         bcomp_pkg::REG_REF_TEMP:   cal.ref_temp          = data;
         bcomp_pkg::REG_TEMP_COEFF: cal.temp_coeff        = data;
         default: ;
      endcase
   endtask

   // Loads a full calibration set, with stray writes past the last register.
   task automatic program_cal(input word_type sens, input word_type off,
                              input word_type tcs, input word_type tco,
                              input word_type tref, input word_type tcoef);
      write_reg(IDX_SPARE_LO, word_type'($urandom));
      write_reg(bcomp_pkg::REG_SENS, sens);
      write_reg(bcomp_pkg::REG_OFF, off);
      write_reg(bcomp_pkg::REG_SENS_TEMP, tcs);
      write_reg(bcomp_pkg::REG_OFF_TEMP, tco);
      write_reg(bcomp_pkg::REG_REF_TEMP, tref);
      write_reg(bcomp_pkg::REG_TEMP_COEFF, tcoef);
      write_reg(IDX_SPARE_HI, word_type'($urandom));
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // Random calibration word, with the extremes drawn often.
   function automatic word_type cal_word();
      int pick;
      pick = $urandom_range(7);
      if (pick == 0) return '0;
      if (pick == 1) return WORD_MAX;
      return word_type'($urandom);
   endfunction

   // Random raw code: full range, extremes or a single set bit.
   function automatic raw_type noise_raw();
      int pick;
      pick = $urandom_range(9);
      if (pick == 0) return '0;
      if (pick == 1) return RAW_MAX;
      if (pick == 2) return raw_type'(1) << $urandom_range(bcomp_pkg::RAW_W - 1);
      return raw_type'($urandom);
   endfunction

   task automatic push_word(input logic func, input raw_type raw);
      conversions_pending.push_back('{func: func, raw: raw});
   endtask

   // Mostly temperature-then-pressure sequences near the reference, the rest noise.
   task automatic queue_random(input int count);
      int      added;
      int      npres;
      raw_type near;
      added = 0;
      while (added < count) begin
         if ($urandom_range(99) < 65) begin
            near = raw_type'((int'(cal.ref_temp) << 8) + $urandom_range(2 ** 21) - 2 ** 20);
            push_word(CONV_TEMP, near);
            npres = $urandom_range(1, 3);
            repeat (npres) push_word(CONV_PRES, raw_type'($urandom));
            added += 1 + npres;
         end else begin
            push_word(1'($urandom_range(1)), noise_raw());
            added++;
         end
      end
   endtask

   // Waits until every queued word has gone in and every result has come back.
   task automatic drain();
      do @(negedge clock);
      while (conversions_pending.size() != 0 || readings_due.size() != 0 || req_ch.valid);
   endtask

   // Main sequence: reset, directed phases, then random calibration phases.
   initial begin
      cal             = '0;
      temp_delta      = '0;
      steady          = 1'b0;
      errors          = 0;
      readings_seen   = 0;
      cycles          = 0;
      hold_left       = 0;
      hold_used       = 1'b0;
      reset           = 1'b1;
      csr_wr_en       = 1'b0;
      csr_index       = '0;
      csr_wr_data     = '0;
      req_ch.valid    = 1'b0;
      req_ch.func     = CONV_TEMP;
      req_ch.raw_code = '0;
      rsp_ch.ready    = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Typical calibration; pressure first runs with the reset delta of zero.
      program_cal(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
      push_word(CONV_PRES, 24'd9085466);
      push_word(CONV_PRES, '0);
      push_word(CONV_PRES, RAW_MAX);
      push_word(CONV_TEMP, raw_type'(cal.ref_temp) << 8);
      push_word(CONV_PRES, 24'd9085466);
      push_word(CONV_TEMP, '0);
      push_word(CONV_PRES, RAW_MAX);
      push_word(CONV_PRES, '0);
      push_word(CONV_TEMP, RAW_MAX);
      push_word(CONV_PRES, RAW_MAX);
      push_word(CONV_PRES, '0);
      push_word(CONV_TEMP, 24'd8569150);
      push_word(CONV_PRES, 24'd9085466);
      drain();

      // Every calibration word at its maximum, with the raw extremes.
      program_cal(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
      push_word(CONV_TEMP, '0);
      push_word(CONV_PRES, RAW_MAX);
      push_word(CONV_PRES, '0);
      push_word(CONV_TEMP, RAW_MAX);
      push_word(CONV_PRES, RAW_MAX);
      push_word(CONV_PRES, '0);
      drain();

      // Every calibration word at zero.
      program_cal('0, '0, '0, '0, '0, '0);
      push_word(CONV_TEMP, RAW_MAX);
      push_word(CONV_PRES, 24'h555555);
      push_word(CONV_TEMP, '0);
      push_word(CONV_PRES, 24'hAAAAAA);
      drain();

      // Random calibration sets; one phase runs both sides without gaps.
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         program_cal(cal_word(), cal_word(), cal_word(), cal_word(), cal_word(), cal_word());
         steady = (ph == 5);
         queue_random(62);
         drain();
         steady = 1'b0;
      end

      // Let any late word surface before the verdict.
      repeat (100) @(posedge clock);
      if (errors == 0 && readings_due.size() == 0) begin
         $display("baro_pressure_temp_compensation_unit verification clean");
      end else begin
         $display("baro_pressure_temp_compensation_unit verification failed");
      end
      $finish;
   end

endmodule
